/* rtl/core/sada_pkg.sv */
// ----------------------------------------------------------------------------
// sada_pkg
// Shared widths, reset values and register map of the stimulus artifact
// detector with triggered running average.
// ----------------------------------------------------------------------------
package sada_pkg;

   localparam int AVG_W      = 24;
   localparam int CNT_W      = 16;
   localparam int NUM_W      = AVG_W + CNT_W + 1;
   localparam int QUO_W      = AVG_W;
   localparam int THR_W      = 14;
   localparam int PLEN_W     = 12;
   localparam int WLEN_W     = 12;
   localparam int SINCE_W    = 13;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [SINCE_W-1:0] SINCE_RESET = 13'd5000;
   localparam logic [SINCE_W-1:0] SINCE_MAX   = 13'd8191;
   localparam logic [CNT_W-1:0]   CNT_MAX     = 16'hFFFF;

   localparam logic [THR_W-1:0]  THRESHOLD_RST = 14'd100;
   localparam logic [PLEN_W-1:0] PLEN_RST      = 12'd150;
   localparam logic [WLEN_W-1:0] WLEN_RST      = 12'd1200;

   localparam logic [AVG_W-1:0] AVG_MAX     = 24'h7FFFFF;
   localparam logic [AVG_W-1:0] AVG_MIN     = 24'h800000;
   localparam logic [QUO_W-1:0] AVG_NEG_MAG = 24'h800000;

   localparam logic [REG_IDX_W-1:0] REG_THRESHOLD     = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_GATE_MODE     = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_DIFF_OUTPUT   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_PULSE_LENGTH  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = 3'd4;

endpackage

/* rtl/core/stim_artifact_detect_average_top.sv */
// ----------------------------------------------------------------------------
// stim_artifact_detect_average_top
// Stimulus artifact detector, TTL pulse timer and triggered running average.
//
// Input items on req_* carry one signed sample plus gate on/off flags; each
// item gives exactly one result item on rsp_*. The user must write registers
// through the csr_* port only while the block is idle; the block itself does
// not enforce this. An item that is not averaged goes from ST_EVAL to ST_FIN.
// An averaged item runs one shared datapath under a sequencer: store read,
// multiply, add, magnitude, rounding, range check, then a restoring divider
// with one quotient bit per cycle (skipped when the quotient saturates),
// then the store write. req_tready is high only while the sequencer is idle;
// one item at a time, so a new item is accepted only after the last one
// leaves its final step. The result sits in an output register, so the next
// item is accepted while it waits; a stalled receiver holds the sequencer
// only at its final step. Reset is synchronous; it restores the state,
// configuration and control registers, not datapath ones or rsp_tdata. The
// average store is not swept: a fill count marks the written prefix and
// entries beyond it read as zero, so the block is ready right after reset.
// ----------------------------------------------------------------------------
module stim_artifact_detect_average_top #(
   parameter int WINDOW_MAX  = 2048,
   parameter int SAMPLE_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // sample, gate_on, gate_off
   input  logic [((SAMPLE_BITS+2+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // signal_out, ttl_level, ttl_rise, ttl_fall, in_window, window_position,
   // average_value, trigger_count
   output logic [((SAMPLE_BITS+5+$clog2(WINDOW_MAX)+sada_pkg::AVG_W
                   +sada_pkg::CNT_W+7)/8)*8-1:0] rsp_tdata,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [sada_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sada_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sada_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);

   localparam int SW     = SAMPLE_BITS;
   localparam int DW     = SW + 1;
   localparam int IW     = $clog2(WINDOW_MAX);
   localparam int XW     = IW + 1;
   localparam int LW     = (XW > sada_pkg::WLEN_W) ? XW : sada_pkg::WLEN_W;
   localparam int CW     = (DW > sada_pkg::THR_W + 3) ? DW : sada_pkg::THR_W + 3;
   localparam int BW     = $clog2(sada_pkg::QUO_W);
   localparam int RSP_B  = DW + 4 + IW + sada_pkg::AVG_W + sada_pkg::CNT_W;
   localparam int RSP_W  = ((RSP_B + 7) / 8) * 8;
   localparam int AW     = sada_pkg::AVG_W;
   localparam int NW     = sada_pkg::NUM_W;
   localparam int QW     = sada_pkg::QUO_W;
   localparam int NCW    = sada_pkg::CNT_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_EVAL, ST_MUL, ST_ADD, ST_ABS, ST_RND, ST_CHK, ST_DIV, ST_WR, ST_FIN
   } state_type;

   state_type state_ff;

   logic [sada_pkg::THR_W-1:0]  thr_ff;
   logic                        gm_ff;
   logic                        dout_ff;
   logic [sada_pkg::PLEN_W-1:0] plen_ff;
   logic [sada_pkg::WLEN_W-1:0] wlen_ff;

   logic signed [SW-1:0] smp_ff;
   logic                 gon_ff;
   logic                 goff_ff;

   logic signed [SW-1:0]         prev_smp_ff;
   logic [DW-1:0]                prev_diff_ff;
   logic                         first_ff;
   logic [sada_pkg::SINCE_W-1:0] since_ff;
   logic                         pulse_ff;
   logic                         pend_ff;
   logic                         wopen_ff;
   logic [XW-1:0]                widx_ff;
   logic [NCW-1:0]               wcnt_ff;
   logic [XW-1:0]                fill_ff;

   logic [DW-1:0]  sig_ff;
   logic           rise_ff;
   logic           fall_ff;
   logic           avgd_ff;
   logic [IW-1:0]  pos_ff;
   logic [AW-1:0]  avg_res_ff;
   logic           old_ok_ff;
   logic [AW-1:0]  rd_ff;
   logic [NW-1:0]  acc_ff;
   logic           neg_ff;
   logic           sat_ff;
   logic [NCW-1:0] rem_ff;
   logic [BW-1:0]  bit_ff;

   logic             rsp_valid_ff;
   logic [RSP_W-1:0] rsp_data_ff;

   logic [AW-1:0] avg_mem [WINDOW_MAX];

   // evaluation of one sample
   logic signed [DW-1:0]         d_in;
   logic [DW-1:0]                diff_in;
   logic [DW-1:0]                sig_in;
   logic [CW-1:0]                diff_c;
   logic [CW-1:0]                pdiff_c;
   logic [CW-1:0]                thr_c;
   logic [CW-1:0]                lim_c;
   logic                         rise_in;
   logic                         fall_in;
   logic                         pend_in;
   logic                         pulse_in;
   logic [sada_pkg::SINCE_W-1:0] since_in;
   logic                         wopen_in;
   logic [XW-1:0]                widx_in;
   logic [NCW-1:0]               wcnt_in;
   logic                         avgd_in;
   logic [IW-1:0]                pos_in;
   logic [LW-1:0]                eff_len;
   logic                         old_ok_in;

   // shared datapath
   logic [NCW-1:0]       div_n;
   logic [NCW-1:0]       nm1;
   logic signed [AW-1:0] old_val;
   logic signed [NW-1:0] prod_c;
   logic signed [NW-1:0] smp256;
   logic [NCW:0]         trial;
   logic                 qbit;
   logic [QW-1:0]        quo;
   logic [AW-1:0]        avg_c;
   logic                 csr_wr;

   always_comb begin
      d_in    = $signed({smp_ff[SW-1], smp_ff}) - $signed({prev_smp_ff[SW-1], prev_smp_ff});
      diff_in = d_in[DW-1] ? DW'(-d_in) : DW'(d_in);
      sig_in  = dout_ff ? diff_in : {smp_ff[SW-1], smp_ff};
      diff_c  = CW'(diff_in);
      pdiff_c = CW'(prev_diff_ff);
      thr_c   = CW'(thr_ff);
      lim_c   = (thr_c << 2) + thr_c;

      pend_in = pend_ff;
      if (gm_ff && !wopen_ff) begin
         if (gon_ff) begin
            pend_in = 1'b1;
         end else if (goff_ff) begin
            pend_in = 1'b0;
         end
      end

      rise_in = !gm_ff && (diff_c > pdiff_c) && (diff_c > thr_c) && (diff_c < lim_c)
                && !wopen_ff && !pend_in && !first_ff;

      since_in = since_ff;
      pulse_in = pulse_ff;
      fall_in  = 1'b0;
      wopen_in = wopen_ff;
      widx_in  = widx_ff;
      wcnt_in  = wcnt_ff;

      if (!gm_ff) begin
         if (rise_in) begin
            since_in = '0;
            pulse_in = 1'b1;
            wopen_in = 1'b1;
            widx_in  = '0;
            if (wcnt_ff != sada_pkg::CNT_MAX) begin
               wcnt_in = wcnt_ff + 1'b1;
            end
         end
         if (pulse_in) begin
            if (since_in > {1'b0, plen_ff}) begin
               pulse_in = 1'b0;
               fall_in  = 1'b1;
            end else if (since_in != sada_pkg::SINCE_MAX) begin
               since_in = since_in + 1'b1;
            end
         end
      end else if (pend_in) begin
         wopen_in = 1'b1;
         widx_in  = '0;
         if (wcnt_ff != sada_pkg::CNT_MAX) begin
            wcnt_in = wcnt_ff + 1'b1;
         end
         pend_in = 1'b0;
      end

      eff_len = (LW'(wlen_ff) > LW'(WINDOW_MAX)) ? LW'(WINDOW_MAX) : LW'(wlen_ff);
      pos_in  = widx_in[IW-1:0];
      if (wopen_in && (LW'(widx_in) < eff_len)) begin
         avgd_in = 1'b1;
         widx_in = widx_in + 1'b1;
      end else begin
         avgd_in  = 1'b0;
         wopen_in = 1'b0;
         widx_in  = '0;
         pend_in  = 1'b0;
      end
      old_ok_in = {1'b0, pos_in} < fill_ff;
   end

   always_comb begin
      div_n   = (wcnt_ff == '0) ? NCW'(1) : wcnt_ff;
      nm1     = div_n - 1'b1;
      old_val = old_ok_ff ? $signed(rd_ff) : '0;
      prod_c  = old_val * $signed({1'b0, nm1});
      smp256  = $signed({{(NW-SW-8){smp_ff[SW-1]}}, smp_ff, 8'b0});
      trial   = {rem_ff, acc_ff[QW-1]};
      qbit    = trial >= {1'b0, div_n};
      quo     = acc_ff[QW-1:0];
      if (!neg_ff) begin
         avg_c = (sat_ff || quo[QW-1]) ? sada_pkg::AVG_MAX : AW'(quo);
      end else begin
         avg_c = (sat_ff || quo > sada_pkg::AVG_NEG_MAG) ? sada_pkg::AVG_MIN : AW'(-quo);
      end
   end

   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= sada_pkg::THRESHOLD_RST;
         gm_ff        <= 1'b0;
         dout_ff      <= 1'b0;
         plen_ff      <= sada_pkg::PLEN_RST;
         wlen_ff      <= sada_pkg::WLEN_RST;
         prev_smp_ff  <= '0;
         prev_diff_ff <= '0;
         first_ff     <= 1'b1;
         since_ff     <= sada_pkg::SINCE_RESET;
         pulse_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         wopen_ff     <= 1'b0;
         widx_ff      <= '0;
         wcnt_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_FIN)) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_wr) begin
            case (csr_paddr[sada_pkg::CSR_ADDR_W-1:2])
               sada_pkg::REG_THRESHOLD:     thr_ff  <= csr_pwdata[sada_pkg::THR_W-1:0];
               sada_pkg::REG_GATE_MODE:     gm_ff   <= csr_pwdata[0];
               sada_pkg::REG_DIFF_OUTPUT:   dout_ff <= csr_pwdata[0];
               sada_pkg::REG_PULSE_LENGTH:  plen_ff <= csr_pwdata[sada_pkg::PLEN_W-1:0];
               sada_pkg::REG_WINDOW_LENGTH: wlen_ff <= csr_pwdata[sada_pkg::WLEN_W-1:0];
               default: ;
            endcase
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  smp_ff   <= req_tdata[SW-1:0];
                  gon_ff   <= req_tdata[SW];
                  goff_ff  <= req_tdata[SW+1];
                  state_ff <= ST_EVAL;
               end
            end
            ST_EVAL: begin
               first_ff     <= 1'b0;
               prev_smp_ff  <= smp_ff;
               prev_diff_ff <= diff_in;
               since_ff     <= since_in;
               pulse_ff     <= pulse_in;
               pend_ff      <= pend_in;
               wopen_ff     <= wopen_in;
               widx_ff      <= widx_in;
               wcnt_ff      <= wcnt_in;
               sig_ff       <= sig_in;
               rise_ff      <= rise_in;
               fall_ff      <= fall_in;
               avgd_ff      <= avgd_in;
               pos_ff       <= avgd_in ? pos_in : '0;
               old_ok_ff    <= old_ok_in;
               avg_res_ff   <= '0;
               state_ff     <= avgd_in ? ST_MUL : ST_FIN;
            end
            ST_MUL: begin
               acc_ff   <= prod_c;
               state_ff <= ST_ADD;
            end
            ST_ADD: begin
               acc_ff   <= $signed(acc_ff) + smp256;
               state_ff <= ST_ABS;
            end
            ST_ABS: begin
               neg_ff   <= acc_ff[NW-1];
               acc_ff   <= acc_ff[NW-1] ? NW'(-acc_ff) : acc_ff;
               state_ff <= ST_RND;
            end
            ST_RND: begin
               acc_ff   <= acc_ff + NW'(div_n >> 1);
               state_ff <= ST_CHK;
            end
            ST_CHK: begin
               bit_ff <= '0;
               if (acc_ff[NW-1:QW] >= {1'b0, div_n}) begin
                  sat_ff   <= 1'b1;
                  state_ff <= ST_WR;
               end else begin
                  sat_ff   <= 1'b0;
                  rem_ff   <= acc_ff[QW+NCW-1:QW];
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               rem_ff            <= qbit ? NCW'(trial - {1'b0, div_n}) : trial[NCW-1:0];
               acc_ff[QW-1:0]    <= {acc_ff[QW-2:0], qbit};
               bit_ff            <= bit_ff + 1'b1;
               if (bit_ff == BW'(QW - 1)) begin
                  state_ff <= ST_WR;
               end
            end
            ST_WR: begin
               avg_res_ff <= avg_c;
               if ({1'b0, pos_ff} >= fill_ff) begin
                  fill_ff <= {1'b0, pos_ff} + 1'b1;
               end
               state_ff <= ST_FIN;
            end
            ST_FIN: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= RSP_W'({wcnt_ff, avg_res_ff, pos_ff, avgd_ff,
                                          fall_ff, rise_ff, pulse_ff, sig_ff});
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EVAL) begin
         rd_ff <= avg_mem[pos_in];
      end
      if (state_ff == ST_WR) begin
         avg_mem[pos_ff] <= avg_c;
      end
   end

   always_comb begin
      case (csr_paddr[sada_pkg::CSR_ADDR_W-1:2])
         sada_pkg::REG_THRESHOLD:     csr_prdata = sada_pkg::CSR_DATA_W'(thr_ff);
         sada_pkg::REG_GATE_MODE:     csr_prdata = sada_pkg::CSR_DATA_W'(gm_ff);
         sada_pkg::REG_DIFF_OUTPUT:   csr_prdata = sada_pkg::CSR_DATA_W'(dout_ff);
         sada_pkg::REG_PULSE_LENGTH:  csr_prdata = sada_pkg::CSR_DATA_W'(plen_ff);
         sada_pkg::REG_WINDOW_LENGTH: csr_prdata = sada_pkg::CSR_DATA_W'(wlen_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
